// ===== rtl/core/crcpd_pkg.sv =====
// Shared types, register map and CRC-16 byte update for the packet deframer.
// Used by crcpd_regs, crcpd_parser and crc_packet_deframer.
package crcpd_pkg;

	localparam int unsigned CFG_ADDR_W = 4;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned M_TDATA_W  = 136;

	localparam logic [1:0] REG_MAGIC    = 2'd0;
	localparam logic [1:0] REG_CRC_INIT = 2'd1;
	localparam logic [1:0] REG_MAX_LEN  = 2'd2;

	localparam logic [15:0] RST_MAGIC    = 16'h0000;
	localparam logic [15:0] RST_CRC_INIT = 16'hFFFF;
	localparam logic [15:0] RST_MAX_LEN  = 16'd1024;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic [1:0] STAT_GOOD    = 2'd0;
	localparam logic [1:0] STAT_CRC_ERR = 2'd1;
	localparam logic [1:0] STAT_LEN_ERR = 2'd2;

	typedef struct packed {
		logic [15:0] magic_word;
		logic [15:0] crc_init;
		logic [15:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		logic [7:0]  frame_type;
		logic [15:0] frame_length;
		logic [15:0] sequence_res;
		logic [1:0]  frame_status;
		logic [31:0] good_frames;
		logic [31:0] bad_frames;
	} result_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/crcpd_regs.sv =====
// APB-style configuration registers of the packet deframer.
// Depends on crcpd_pkg for the register map and reset values.
module crcpd_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [crcpd_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [crcpd_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [crcpd_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                pready,
	output crcpd_pkg::cfg_t                     cfg
);
	import crcpd_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_word <= RST_MAGIC;
			cfg_q.crc_init   <= RST_CRC_INIT;
			cfg_q.max_length <= RST_MAX_LEN;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MAGIC:    cfg_q.magic_word <= pwdata[15:0];
				REG_CRC_INIT: cfg_q.crc_init   <= pwdata[15:0];
				REG_MAX_LEN:  cfg_q.max_length <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MAGIC:    prdata = {16'h0000, cfg_q.magic_word};
			REG_CRC_INIT: prdata = {16'h0000, cfg_q.crc_init};
			REG_MAX_LEN:  prdata = {16'h0000, cfg_q.max_length};
			default:      prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/crcpd_parser.sv =====
// Frame phase machine, header capture, byte-wise CRC-16 and frame counters.
// Depends on crcpd_pkg; produces at most one result per accepted byte.
module crcpd_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  crcpd_pkg::cfg_t      cfg,
	input  logic                 byte_en,
	input  logic [7:0]           rx_byte,
	output logic                 res_valid,
	output crcpd_pkg::result_t   res
);
	import crcpd_pkg::*;

	typedef enum logic [3:0] {
		PH_MAGIC1  = 4'd0,
		PH_MAGIC2  = 4'd1,
		PH_TYPE    = 4'd2,
		PH_LEN1    = 4'd3,
		PH_LEN2    = 4'd4,
		PH_SEQ1    = 4'd5,
		PH_SEQ2    = 4'd6,
		PH_PAYLOAD = 4'd7,
		PH_CRC1    = 4'd8,
		PH_CRC2    = 4'd9
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  type_q, type_d;
	logic [15:0] length_q, length_d;
	logic [15:0] seq_q, seq_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  crc_lo_q, crc_lo_d;
	logic [15:0] crc_q, crc_d;
	logic [31:0] bad_q, bad_d;
	logic [31:0] good_q, good_d;
	logic [15:0] crc_upd;
	logic [15:0] len_full;
	logic [15:0] count_inc;

	assign crc_upd   = crc_byte(crc_q, rx_byte);
	assign len_full  = {rx_byte, length_q[7:0]};
	assign count_inc = count_q + 16'd1;

	always_comb begin
		phase_d   = phase_q;
		type_d    = type_q;
		length_d  = length_q;
		seq_d     = seq_q;
		count_d   = count_q;
		crc_lo_d  = crc_lo_q;
		crc_d     = crc_q;
		bad_d     = bad_q;
		good_d    = good_q;
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_q)
			PH_MAGIC2: begin
				if (rx_byte == cfg.magic_word[15:8]) begin
					phase_d  = PH_TYPE;
					crc_d    = cfg.crc_init;
					type_d   = '0;
					length_d = '0;
					seq_d    = '0;
					count_d  = '0;
					crc_lo_d = '0;
				end else if (rx_byte != cfg.magic_word[7:0]) begin
					phase_d = PH_MAGIC1;
				end
			end
			PH_TYPE: begin
				type_d  = rx_byte;
				crc_d   = crc_upd;
				phase_d = PH_LEN1;
			end
			PH_LEN1: begin
				length_d = {8'h00, rx_byte};
				crc_d    = crc_upd;
				phase_d  = PH_LEN2;
			end
			PH_LEN2: begin
				length_d = len_full;
				crc_d    = crc_upd;
				if (len_full > cfg.max_length) begin
					bad_d     = bad_q + 32'd1;
					phase_d   = PH_MAGIC1;
					res_valid = 1'b1;
					res.result_kind  = KIND_VERDICT;
					res.frame_status = STAT_LEN_ERR;
				end else begin
					phase_d = PH_SEQ1;
				end
			end
			PH_SEQ1: begin
				seq_d   = {8'h00, rx_byte};
				crc_d   = crc_upd;
				phase_d = PH_SEQ2;
			end
			PH_SEQ2: begin
				seq_d   = {rx_byte, seq_q[7:0]};
				crc_d   = crc_upd;
				count_d = '0;
				phase_d = (length_q == 16'd0) ? PH_CRC1 : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				crc_d   = crc_upd;
				count_d = count_inc;
				if (count_inc >= length_q) begin
					phase_d = PH_CRC1;
				end
				res_valid = 1'b1;
				res.result_kind  = KIND_PAYLOAD;
				res.data_byte    = rx_byte;
				res.byte_index   = count_q;
				res.sequence_res = seq_q;
				res.frame_status = STAT_GOOD;
			end
			PH_CRC1: begin
				crc_lo_d = rx_byte;
				phase_d  = PH_CRC2;
			end
			PH_CRC2: begin
				phase_d   = PH_MAGIC1;
				res_valid = 1'b1;
				res.result_kind  = KIND_VERDICT;
				res.sequence_res = seq_q;
				if ({rx_byte, crc_lo_q} == crc_q) begin
					good_d = good_q + 32'd1;
					res.frame_status = STAT_GOOD;
				end else begin
					bad_d = bad_q + 32'd1;
					res.frame_status = STAT_CRC_ERR;
				end
			end
			default: begin
				phase_d = (rx_byte == cfg.magic_word[7:0]) ? PH_MAGIC2 : PH_MAGIC1;
			end
		endcase
		res.frame_type   = type_d;
		res.frame_length = length_d;
		res.good_frames  = good_d;
		res.bad_frames   = bad_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MAGIC1;
			type_q   <= '0;
			length_q <= '0;
			seq_q    <= '0;
			count_q  <= '0;
			crc_lo_q <= '0;
			crc_q    <= RST_CRC_INIT;
			bad_q    <= '0;
			good_q   <= '0;
		end else if (byte_en) begin
			phase_q  <= phase_d;
			type_q   <= type_d;
			length_q <= length_d;
			seq_q    <= seq_d;
			count_q  <= count_d;
			crc_lo_q <= crc_lo_d;
			crc_q    <= crc_d;
			bad_q    <= bad_d;
			good_q   <= good_d;
		end
	end

endmodule

// ===== rtl/core/crc_packet_deframer.sv =====
// Top level of the CRC-16 packet deframer: config port, parser, output register.
// Depends on crcpd_pkg, crcpd_regs and crcpd_parser.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one received byte per request.
//   m_tvalid/m_tready/m_tdata/m_tuser carry results: a payload byte
//   (m_tuser = 0) as it arrives, or a frame verdict (m_tuser = 1) after the
//   second CRC byte or after a length above max_length.
//   Bytes that yield no result (hunt, header, CRC) produce nothing on m_*.
//   A result appears on m_* in the cycle after its byte is accepted.
//   Throughput: one byte per cycle unless m_* stalls; phase step and byte-wide
//   CRC update complete between the input handshake and the output register.
//   s_tready is high while the output register is empty or being drained,
//   so a stalled receiver holds the pending result and back-pressures s_*.
//   Reset clears the phase machine to the start-word hunt, zeroes both frame
//   counters and loads the registers with magic 0, CRC seed 0xFFFF and
//   length limit 1024. Write registers through APB only while idle.
module crc_packet_deframer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,  // [7:0] rx_byte
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [7:0] data_byte, [23:8] byte_index, [31:24] frame_type,
	// [47:32] frame_length, [63:48] sequence_res, [65:64] frame_status,
	// [97:66] good_frames, [129:98] bad_frames, [135:130] zero
	output logic [crcpd_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic                                m_tuser,  // [0] result_kind
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [crcpd_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [crcpd_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [crcpd_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                pready
);
	import crcpd_pkg::*;

	cfg_t    cfg;
	logic    byte_en;
	logic    res_valid;
	result_t res;
	result_t out_q;
	logic    out_valid_q;

	crcpd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crcpd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.byte_en   (byte_en),
		.rx_byte   (s_tdata),
		.res_valid (res_valid),
		.res       (res)
	);

	assign s_tready = ~out_valid_q | m_tready;
	assign byte_en  = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (byte_en) begin
			out_valid_q <= res_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_en) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.result_kind;
	assign m_tdata  = {6'b000000, out_q.bad_frames, out_q.good_frames, out_q.frame_status,
		out_q.sequence_res, out_q.frame_length, out_q.frame_type, out_q.byte_index,
		out_q.data_byte};

endmodule
